FILE: rtl/core/lstm_cell_gate_update_top_macros.svh
// Assertion macros for the checker file.
`ifndef LSTM_CELL_GATE_UPDATE_TOP_MACROS_SVH
`define LSTM_CELL_GATE_UPDATE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LCGU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define LCGU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lcgu_pkg.sv
// -----------------------------------------------------------------------------
// lcgu_pkg
// Types, constants and activation helpers for the LSTM cell update.
// -----------------------------------------------------------------------------
package lcgu_pkg;

   localparam int HIDDEN_DEPTH = 1024;
   localparam int IDX_W = 10;
   localparam int DATA_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FGT_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_ZONE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_ZONE = 2'd2;

   localparam logic [16:0] ONE_Q15 = 17'd32768;

   typedef struct packed {
      logic [IDX_W-1:0]         elem_index;
      logic signed [DATA_W-1:0] input_gate_pre;
      logic signed [DATA_W-1:0] cand_gate_pre;
      logic signed [DATA_W-1:0] forget_gate_pre;
      logic signed [DATA_W-1:0] output_gate_pre;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] hidden_out;
      logic signed [DATA_W-1:0] cell_new;
      logic signed [DATA_W-1:0] hidden_kept;
   } rsp_type;

   // sigmoid of signed 18 bit Q6.11 input, result 0..32768 as 17 bit unsigned
   function automatic logic [16:0] sig_q15(input logic signed [17:0] x);
      logic [17:0] a;
      logic [17:0] s;
      begin
         a = x[17] ? 18'(-x) : 18'(x);
         if (a >= 18'd10240) s = 18'd32768;
         else if (a >= 18'd4864) s = (a >> 1) + 18'd27648;
         else if (a >= 18'd2048) s = (a << 1) + 18'd20480;
         else s = (a << 2) + 18'd16384;
         sig_q15 = x[17] ? 17'(18'd32768 - s) : s[16:0];
      end
   endfunction

   // tanh of signed 17 bit input, result -32768..32768 as 18 bit signed
   function automatic logic signed [17:0] tanh_q15(input logic signed [16:0] x);
      logic [16:0] s;
      begin
         s = sig_q15({x, 1'b0});
         tanh_q15 = $signed({s, 1'b0}) - 18'sd32768;
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) sat16 = 16'sh7FFF;
      else if (v < -40'sd32768) sat16 = 16'sh8000;
      else sat16 = v[15:0];
   endfunction

endpackage

FILE: rtl/core/lcgu_stream_if.sv
// -----------------------------------------------------------------------------
// lcgu_stream_if
// Valid/ready channel carrying one packed word.
// -----------------------------------------------------------------------------
interface lcgu_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/lcgu_store.sv
// -----------------------------------------------------------------------------
// lcgu_store
// Cell and hidden state memory with registered read and a clearing sweep.
// -----------------------------------------------------------------------------
module lcgu_store (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [lcgu_pkg::IDX_W-1:0]      rd_addr,
   output logic [2*lcgu_pkg::DATA_W-1:0]   rd_data,
   input  logic                            wr_en,
   input  logic [lcgu_pkg::IDX_W-1:0]      wr_addr,
   input  logic [2*lcgu_pkg::DATA_W-1:0]   wr_data,
   output logic                            clear_busy
);
   logic [2*lcgu_pkg::DATA_W-1:0] mem [lcgu_pkg::HIDDEN_DEPTH];
   logic [lcgu_pkg::IDX_W:0]      clr_ff, clr_in;

   assign clear_busy = !clr_ff[lcgu_pkg::IDX_W];
   assign clr_in = clear_busy ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (clear_busy) mem[clr_ff[lcgu_pkg::IDX_W-1:0]] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/lstm_cell_gate_update_top.sv
// -----------------------------------------------------------------------------
// lstm_cell_gate_update_top
// LSTM element update: gate activations, cell and hidden, zoneout.
// -----------------------------------------------------------------------------
// req carries one hidden element per word: index and four gate pre-activations.
// rsp returns index, hidden output, new cell and kept hidden value.
// csr_we/csr_index/csr_wdata write the forget offset (0), cell_zoneout (1) and
// hidden_zoneout (2); write only while the block is idle.
// Throughput is one word per cycle when no rsp stall, index hold or clearing
// sweep holds the flow. The six register stages are request and memory read,
// activations, cell products, cell sum and tanh, output product, zoneout blend.
// The state memory is read when a word enters stage 1 and written when its rsp
// word is taken; the stage 6 word and the last written word are forwarded.
// A word whose index matches a word in stages 2 to 5 waits in stage 1 until
// that word has moved on to stage 6, from where its state is forwarded.
// After reset the memory is cleared entry by entry, during which req_ready
// is low; CSR writes are taken as ever.
// When rsp_ready is low while stage 6 holds a word the whole pipeline holds;
// req_ready follows the output stage, so nothing is lost or repeated.
module lstm_cell_gate_update_top (
   input  logic                            clock,
   input  logic                            reset,
   lcgu_stream_if.sink                     req,
   lcgu_stream_if.source                   rsp,
   input  logic                            csr_we,
   input  logic [lcgu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcgu_pkg::DATA_W-1:0]     csr_wdata
);
   localparam int NS = 6;

   logic signed [15:0] fbias_ff;
   logic [15:0]        czone_ff, hzone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fbias_ff <= '0;
         czone_ff <= '0;
         hzone_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            lcgu_pkg::CSR_FGT_OFFSET:  fbias_ff <= csr_wdata;
            lcgu_pkg::CSR_CELL_ZONE:   czone_ff <= csr_wdata;
            lcgu_pkg::CSR_HIDDEN_ZONE: hzone_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic clear_busy, adv, adv1, haz, take;
   logic [NS:1] v_ff, v_in;

   assign adv = !v_ff[NS] || rsp.ready;
   assign adv1 = adv && !haz;
   assign req.ready = adv1 && !clear_busy;
   assign take = req.valid && req.ready;

   always_comb begin
      v_in = v_ff;
      if (adv) v_in = {v_ff[NS-1:2], v_ff[1] && !haz, adv1 ? take : v_ff[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= v_in;
   end

   // stage payloads
   lcgu_pkg::req_type s1_ff;
   logic [9:0] idx_ff [2:NS-1];
   logic signed [17:0] ig_ff, fg_ff, og2_ff, og3_ff, og4_ff;
   logic signed [17:0] gg_ff;
   logic signed [15:0] oc2_ff, oc3_ff, oc4_ff, oc5_ff;
   logic signed [15:0] oh2_ff, oh3_ff, oh4_ff, oh5_ff;
   logic signed [33:0] p1_ff, p2_ff;
   logic signed [15:0] cn4_ff, cn5_ff, ho5_ff;
   logic signed [17:0] tc4_ff;
   logic signed [15:0] rc_ff, rh_ff, rn_ff, rk_ff;
   logic [9:0] ri_ff;
   logic wen_ff;
   logic [9:0] wadr_ff;
   logic [31:0] wdat_ff;
   logic wr_take, s1_in_range;

   assign wr_take = rsp.valid && rsp.ready &&
                    ({1'b0, ri_ff} < 11'(lcgu_pkg::HIDDEN_DEPTH));
   assign s1_in_range = {1'b0, s1_ff.elem_index} < 11'(lcgu_pkg::HIDDEN_DEPTH);

   logic [31:0] rd_data;
   lcgu_store u_store (
      .clock(clock), .reset(reset),
      .rd_en(adv1), .rd_addr(req.data.elem_index), .rd_data(rd_data),
      .wr_en(wr_take), .wr_addr(ri_ff), .wr_data({rc_ff, rk_ff}),
      .clear_busy(clear_busy)
   );

   // forward old state from the last written word and from stage 6
   logic signed [15:0] oc_fw, oh_fw;
   logic signed [15:0] ck6, hk6;
   always_comb begin
      oc_fw = rd_data[31:16];
      oh_fw = rd_data[15:0];
      if (wen_ff && wadr_ff == s1_ff.elem_index) begin
         oc_fw = wdat_ff[31:16];
         oh_fw = wdat_ff[15:0];
      end
      if (v_ff[NS] && ri_ff == s1_ff.elem_index) begin
         oc_fw = ck6;
         oh_fw = hk6;
      end
   end
   // hold stage 1 while an older word of the same index sits in stages 2..5
   always_comb begin
      haz = 1'b0;
      for (int k = 2; k < NS; k++)
         if (v_ff[1] && v_ff[k] && idx_ff[k] == s1_ff.elem_index) haz = 1'b1;
   end

   // stage 1: register request
   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= req.data;
   end

   // stage 2: activations
   logic signed [16:0] fsum;
   assign fsum = 17'(s1_ff.forget_gate_pre) + 17'(fbias_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[2] <= s1_ff.elem_index;
         ig_ff <= 18'(lcgu_pkg::sig_q15(18'(s1_ff.input_gate_pre)));
         gg_ff <= lcgu_pkg::tanh_q15(17'(s1_ff.cand_gate_pre));
         fg_ff <= 18'(lcgu_pkg::sig_q15(18'(fsum)));
         og2_ff <= 18'(lcgu_pkg::sig_q15(18'(s1_ff.output_gate_pre)));
         oc2_ff <= s1_in_range ? oc_fw : '0;
         oh2_ff <= s1_in_range ? oh_fw : '0;
      end
   end

   // stage 3: cell products
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[3] <= idx_ff[2];
         p1_ff <= 34'(oc2_ff) * 34'(fg_ff);
         p2_ff <= 34'(ig_ff) * 34'(gg_ff);
         og3_ff <= og2_ff; oc3_ff <= oc2_ff; oh3_ff <= oh2_ff;
      end
   end

   // stage 4: cell sum, round, saturate, tanh
   logic signed [39:0] acc, accr;
   logic signed [15:0] cnew;
   assign acc = (40'(p1_ff) <<< 4) + 40'(p2_ff) + 40'sd262144;
   assign accr = acc >>> 19;
   assign cnew = lcgu_pkg::sat16(accr);
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[4] <= idx_ff[3];
         cn4_ff <= cnew;
         tc4_ff <= lcgu_pkg::tanh_q15(17'(cnew));
         og4_ff <= og3_ff; oc4_ff <= oc3_ff; oh4_ff <= oh3_ff;
      end
   end

   // stage 5: hidden product
   logic signed [39:0] hp;
   assign hp = ((40'(og4_ff) * 40'(tc4_ff)) + 40'sd262144) >>> 19;
   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff[5] <= idx_ff[4];
         ho5_ff <= lcgu_pkg::sat16(hp);
         cn5_ff <= cn4_ff; oc5_ff <= oc4_ff; oh5_ff <= oh4_ff;
      end
   end

   // stage 6: zoneout blends
   logic [16:0] wc, wh;
   logic signed [39:0] bc, bh;
   assign wc = (czone_ff > 16'd32768) ? lcgu_pkg::ONE_Q15 : {1'b0, czone_ff};
   assign wh = (hzone_ff > 16'd32768) ? lcgu_pkg::ONE_Q15 : {1'b0, hzone_ff};
   assign bc = (40'(cn5_ff) * 40'($signed({1'b0, lcgu_pkg::ONE_Q15 - wc}))
              + 40'(oc5_ff) * 40'($signed({1'b0, wc})) + 40'sd16384) >>> 15;
   assign bh = (40'(ho5_ff) * 40'($signed({1'b0, lcgu_pkg::ONE_Q15 - wh}))
              + 40'(oh5_ff) * 40'($signed({1'b0, wh})) + 40'sd16384) >>> 15;
   always_ff @(posedge clock) begin
      if (adv) begin
         ri_ff <= idx_ff[5];
         rh_ff <= ho5_ff;
         rn_ff <= cn5_ff;
         rk_ff <= lcgu_pkg::sat16(bh);
         rc_ff <= lcgu_pkg::sat16(bc);
      end
   end
   assign ck6 = rc_ff;
   assign hk6 = rk_ff;

   // hold the last written word for forwarding
   always_ff @(posedge clock) begin
      if (reset) wen_ff <= 1'b0;
      else if (adv) wen_ff <= v_ff[NS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         wadr_ff <= ri_ff;
         wdat_ff <= {rc_ff, rk_ff};
      end
   end

   assign rsp.valid = v_ff[NS];
   assign rsp.data = '{out_index: ri_ff, hidden_out: rh_ff, cell_new: rn_ff,
                       hidden_kept: rk_ff};
endmodule

FILE: rtl/core/lcgu_checker.sv
// -----------------------------------------------------------------------------
// lcgu_checker
// Port level checks of the LSTM update block.
// -----------------------------------------------------------------------------
`include "lstm_cell_gate_update_top_macros.svh"
module lcgu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input lcgu_pkg::rsp_type rsp_data
);
   `LCGU_ASSERT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `LCGU_ASSERT(rsp_stable_a, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp changed")
   `LCGU_ASSERT(stall_a, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "req taken in stall")
   `LCGU_ASSERT_ALWAYS(rst_a, clock, $past(reset) |-> !rsp_valid, "rsp after reset")
endmodule

bind lstm_cell_gate_update_top lcgu_checker u_lcgu_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: bench/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// LSTM element update bench: a directed table, then random words over several
// CSR settings. Every rsp word is checked field by field against a typed row
// or an in-bench model of the activations, cell and hidden update and zoneout.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lcgu_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      lcgu_pkg::req_type word;
      bit                typed;
      lcgu_pkg::rsp_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [lcgu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lcgu_pkg::DATA_W-1:0] csr_wdata = '0;

   lcgu_stream_if #(.word_type(lcgu_pkg::req_type)) req_if ();
   lcgu_stream_if #(.word_type(lcgu_pkg::rsp_type)) rsp_if ();

   lstm_cell_gate_update_top u_dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic signed [15:0] cell_mem [lcgu_pkg::HIDDEN_DEPTH];
   logic signed [15:0] hid_mem [lcgu_pkg::HIDDEN_DEPTH];
   int fgt_offset_q, cell_zone_q, hid_zone_q;
   lcgu_pkg::rsp_type pending_rsp[$];
   int errors = 0;
   int send_idle = 6;
   int recv_stall = 65;

   function automatic int sigm(int x);
      int a, s;
      a = (x < 0) ? -x : x;
      if (a >= 10240) s = 32768;
      else if (a >= 4864) s = a / 2 + 27648;
      else if (a >= 2048) s = 2 * a + 20480;
      else s = 4 * a + 16384;
      return (x < 0) ? 32768 - s : s;
   endfunction

   function automatic int tanhq(int x);
      return 2 * sigm(2 * x) - 32768;
   endfunction

   function automatic int sat_rnd(longint v, int n);
      longint r;
      r = (v + (64'sd1 <<< (n - 1))) >>> n;
      if (r > 32767) return 32767;
      if (r < -32768) return -32768;
      return int'(r);
   endfunction

   function automatic int zone_mix(int nv, int ov, int z);
      int w;
      w = (z > 32768) ? 32768 : z;
      return sat_rnd(longint'(nv) * (32768 - w) + longint'(ov) * w, 15);
   endfunction

   function automatic lcgu_pkg::rsp_type cell_update(lcgu_pkg::req_type w);
      lcgu_pkg::rsp_type r;
      int oc, oh, ig, gg, fg, og, cn, ho;
      longint acc;
      oc = cell_mem[w.elem_index];
      oh = hid_mem[w.elem_index];
      ig = sigm(int'(w.input_gate_pre));
      gg = tanhq(int'(w.cand_gate_pre));
      fg = sigm(int'(w.forget_gate_pre) + fgt_offset_q);
      og = sigm(int'(w.output_gate_pre));
      acc = longint'(oc) * fg * 16 + longint'(ig) * gg;
      cn = sat_rnd(acc, 19);
      ho = sat_rnd(longint'(og) * tanhq(cn), 19);
      r.out_index = w.elem_index;
      r.cell_new = 16'(cn);
      r.hidden_out = 16'(ho);
      r.hidden_kept = 16'(zone_mix(ho, oh, hid_zone_q));
      cell_mem[w.elem_index] = 16'(zone_mix(cn, oc, cell_zone_q));
      hid_mem[w.elem_index] = r.hidden_kept;
      return r;
   endfunction

   task automatic report_bad(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   always @(negedge clock)
      rsp_if.ready <= ($urandom % 100) >= recv_stall;

   always @(posedge clock) begin
      lcgu_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            report_bad($sformatf("unexpected word index %0d", rsp_if.data.out_index));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.data.out_index !== want.out_index)
               report_bad($sformatf("out_index %0d want %0d",
                  rsp_if.data.out_index, want.out_index));
            if (rsp_if.data.hidden_out !== want.hidden_out)
               report_bad($sformatf("idx %0d hidden_out %0d want %0d", want.out_index,
                  rsp_if.data.hidden_out, want.hidden_out));
            if (rsp_if.data.cell_new !== want.cell_new)
               report_bad($sformatf("idx %0d cell_new %0d want %0d", want.out_index,
                  rsp_if.data.cell_new, want.cell_new));
            if (rsp_if.data.hidden_kept !== want.hidden_kept)
               report_bad($sformatf("idx %0d hidden_kept %0d want %0d", want.out_index,
                  rsp_if.data.hidden_kept, want.hidden_kept));
         end
      end
   end

   task automatic send_word(lcgu_pkg::req_type w, bit typed,
                            lcgu_pkg::rsp_type typed_rsp);
      lcgu_pkg::rsp_type got;
      @(negedge clock);
      while (($urandom % 100) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      got = cell_update(w);
      pending_rsp.push_back(typed ? typed_rsp : got);
   endtask

   task automatic drain;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(logic [lcgu_pkg::CSR_IDX_W-1:0] idx,
                            logic [lcgu_pkg::DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         lcgu_pkg::CSR_FGT_OFFSET:  fgt_offset_q = int'($signed(val));
         lcgu_pkg::CSR_CELL_ZONE:   cell_zone_q = int'(val);
         lcgu_pkg::CSR_HIDDEN_ZONE: hid_zone_q = int'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] rand_gate();
      if ($urandom % 2) return 16'($urandom);
      return 16'($urandom_range(0, 16000) - 8000);
   endfunction

   task automatic send_random(int count);
      lcgu_pkg::req_type w;
      lcgu_pkg::rsp_type none;
      none = '0;
      repeat (count) begin
         w.elem_index = ($urandom % 10 < 7) ? 10'($urandom_range(0, 15))
                                            : 10'($urandom_range(0, 1023));
         w.input_gate_pre = rand_gate();
         w.cand_gate_pre = rand_gate();
         w.forget_gate_pre = rand_gate();
         w.output_gate_pre = rand_gate();
         send_word(w, 1'b0, none);
      end
   endtask

   dir_row_type dir_rows[] = '{
      '{'{10'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{10'd0, 16'sd0, 16'sd0, 16'sd0}},
      '{'{10'd5, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
        '{10'd5, 16'sd1536, 16'sd2048, 16'sd1536}},
      '{'{10'd5, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
      '{'{10'd5, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
      '{'{10'd1023, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767}, 1'b0, '0},
      '{'{10'd1023, 16'sd10240, 16'sd4864, 16'sd2048, -16'sd10240}, 1'b0, '0},
      '{'{10'd1023, -16'sd4864, 16'sd2432, -16'sd2048, 16'sd4863}, 1'b0, '0},
      '{'{10'd512, 16'sd2047, -16'sd2432, 16'sd10239, -16'sd1}, 1'b0, '0},
      '{'{10'd512, -16'sd21846, 16'sd21845, 16'sd32767, 16'sd1}, 1'b0, '0},
      '{'{10'd341, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, '0},
      '{'{10'd682, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0},
      '{'{10'd682, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, '0}
   };

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      for (int k = 0; k < lcgu_pkg::HIDDEN_DEPTH; k++) begin
         cell_mem[k] = '0;
         hid_mem[k] = '0;
      end
      fgt_offset_q = 0;
      cell_zone_q = 0;
      hid_zone_q = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      send_random(270);
      drain();

      csr_write(lcgu_pkg::CSR_FGT_OFFSET, 16'h7FFF);
      csr_write(lcgu_pkg::CSR_CELL_ZONE, 16'h8000);
      csr_write(lcgu_pkg::CSR_HIDDEN_ZONE, 16'h4000);
      csr_write(CSR_UNUSED, 16'h1234);
      send_idle = 65;
      recv_stall = 6;
      send_random(200);
      drain();

      csr_write(lcgu_pkg::CSR_FGT_OFFSET, 16'h8000);
      csr_write(lcgu_pkg::CSR_CELL_ZONE, 16'hFFFF);
      csr_write(lcgu_pkg::CSR_HIDDEN_ZONE, 16'hFFFF);
      send_random(120);
      drain();

      csr_write(lcgu_pkg::CSR_FGT_OFFSET, 16'($urandom));
      csr_write(lcgu_pkg::CSR_CELL_ZONE, 16'($urandom_range(1, 32767)));
      csr_write(lcgu_pkg::CSR_HIDDEN_ZONE, 16'($urandom_range(1, 32767)));
      send_idle = 0;
      recv_stall = 0;
      send_random(130);
      drain();

      csr_write(lcgu_pkg::CSR_FGT_OFFSET, 16'h0000);
      csr_write(lcgu_pkg::CSR_CELL_ZONE, 16'h0000);
      csr_write(lcgu_pkg::CSR_HIDDEN_ZONE, 16'h0000);
      send_random(120);
      drain();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
